/* design/square_columnar_transposer_defines.svh */
// assertion macros for the square columnar transposer
// used by the top level only, needs i_clk and i_rst_n in scope
`ifndef SQUARE_COLUMNAR_TRANSPOSER_DEFINES_SVH
`define SQUARE_COLUMNAR_TRANSPOSER_DEFINES_SVH

// checked outside reset
`define SCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* design/sct_pkg.sv */
// shared types, constants and a function of the square columnar transposer
// no dependencies
package sct_pkg;

    localparam int CHAR_W        = 8;
    localparam int MAX_CHARS_DEF = 48;
    localparam int MAX_RESULTS   = 56;
    localparam int RES_W         = $clog2(MAX_RESULTS + 1);
    localparam int SQRT_MAX      = 8;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;

    typedef enum logic [1:0] {
        S_LOAD,
        S_ISSUE,
        S_DATA,
        S_EMPTY
    } t_state;

    // exact ceil(sqrt(n)) for n up to SQRT_MAX squared
    function automatic int ceil_sqrt(input int n);
        int c;
        c = 0;
        for (int k = 0; k < SQRT_MAX; k++) begin
            if (k * k < n) begin
                c = c + 1;
            end
        end
        return c;
    endfunction

endpackage

/* design/sct_in_if.sv */
// request channel carrying message bytes into the transposer
// depends on sct_pkg
interface sct_in_if;
    import sct_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

/* design/sct_out_if.sv */
// request channel carrying transposed bytes out of the transposer
// depends on sct_pkg
interface sct_out_if;
    import sct_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              out_last;
    logic              no_char;

    modport source (output valid, output out_char, output out_last, output no_char,
                    input ready);
    modport sink   (input valid, input out_char, input out_last, input no_char,
                    output ready);
endinterface

/* design/sct_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module sct_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 48,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/square_columnar_transposer.sv */
// square columnar transposer top level
// depends on sct_pkg, sct_in_if, sct_out_if, sct_ram and the defines header
//
// i_in takes one message byte per request; spaces and zero bytes are not
// stored, and bytes past MAX_CHARS are dropped. ready is high while the
// block loads, so bytes go in at one per cycle. The request with in_last set
// ends the message, even when its own byte is dropped, and starts output.
// The column count is ceil(sqrt(L)) over the stored length L; o_out then
// gives each column top to bottom followed by one space, the last space
// marked with out_last. An empty message gives a single request with
// no_char and out_last set. Each stored byte is first read from the store
// and then loaded into the output register; each column space is loaded
// into the output register directly. Up to MAX_RESULTS results are sent.
// i_in stays low on ready until the final result sits in the output
// register. A stall on o_out holds the result and pauses the walk. Reset
// clears the stored count and drops any result that was waiting; the store
// itself needs no clearing.
`include "square_columnar_transposer_defines.svh"

module square_columnar_transposer #(
    parameter int MAX_CHARS = sct_pkg::MAX_CHARS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sct_in_if.sink    i_in,
    sct_out_if.source o_out
);
    import sct_pkg::*;

    localparam int CNT_W  = $clog2(MAX_CHARS + 1);
    localparam int IDX_W  = CNT_W + 1;
    localparam int ADDR_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_len, n_len;
    logic [CNT_W-1:0]   r_cols, n_cols;
    logic [CNT_W-1:0]   r_x, n_x;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [RES_W-1:0]   r_n, n_n;
    logic               r_ovalid, n_ovalid;
    logic [CHAR_W-1:0]  r_ochar, n_ochar;
    logic               r_olast, n_olast;
    logic               r_onochar, n_onochar;

    logic               w_ready;
    logic               w_in_acc;
    logic               w_store;
    logic [CNT_W-1:0]   w_len;
    logic               w_out_free;
    logic               w_out_load;
    logic               w_idx_in;
    logic               w_res_end;
    logic               w_col_end;
    logic               w_re;
    logic [CHAR_W-1:0]  w_rdata;

    assign w_ready    = (r_state == S_LOAD);
    assign w_in_acc   = i_in.valid && w_ready;
    assign w_store    = w_in_acc && (i_in.in_char != NUL_CHAR) &&
                        (i_in.in_char != SPACE_CHAR) && (r_count < CNT_W'(MAX_CHARS));
    assign w_len      = w_store ? CNT_W'(r_count + 1'b1) : r_count;
    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_idx_in   = r_idx < IDX_W'(r_len);
    assign w_res_end  = (r_n == RES_W'(MAX_RESULTS - 1));
    assign w_col_end  = (CNT_W'(r_x + 1'b1) == r_cols);

    sct_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_CHARS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_in.in_char),
        .i_re    (w_re),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_in_acc && i_in.in_last) begin
                    n_state = (w_len == '0) ? S_EMPTY : S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (w_idx_in) begin
                    n_state = S_DATA;
                end else if (w_out_free && (w_col_end || w_res_end)) begin
                    n_state = S_LOAD;
                end
            end
            S_DATA: begin
                if (w_out_free) begin
                    n_state = w_res_end ? S_LOAD : S_ISSUE;
                end
            end
            S_EMPTY: begin
                if (w_out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        n_count    = r_count;
        n_len      = r_len;
        n_cols     = r_cols;
        n_x        = r_x;
        n_idx      = r_idx;
        n_n        = r_n;
        n_ochar    = r_ochar;
        n_olast    = r_olast;
        n_onochar  = r_onochar;
        w_re       = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    n_count = w_len;
                    if (i_in.in_last) begin
                        n_count = '0;
                        n_len   = w_len;
                        n_cols  = CNT_W'(ceil_sqrt(int'(w_len)));
                        n_x     = '0;
                        n_idx   = '0;
                        n_n     = '0;
                    end
                end
            end
            S_ISSUE: begin
                if (w_idx_in) begin
                    w_re = 1'b1;
                end else if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_ochar    = SPACE_CHAR;
                    n_olast    = w_col_end || w_res_end;
                    n_onochar  = 1'b0;
                    n_n        = RES_W'(r_n + 1'b1);
                    n_x        = CNT_W'(r_x + 1'b1);
                    n_idx      = IDX_W'(r_x) + 1'b1;
                end
            end
            S_DATA: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_ochar    = w_rdata;
                    n_olast    = w_res_end;
                    n_onochar  = 1'b0;
                    n_n        = RES_W'(r_n + 1'b1);
                    n_idx      = r_idx + IDX_W'(r_cols);
                end
            end
            S_EMPTY: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_ochar    = NUL_CHAR;
                    n_olast    = 1'b1;
                    n_onochar  = 1'b1;
                end
            end
            default: begin
                w_re       = 1'b0;
                w_out_load = 1'b0;
            end
        endcase
        n_ovalid = w_out_load ? 1'b1 : (r_ovalid && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len     <= n_len;
        r_cols    <= n_cols;
        r_x       <= n_x;
        r_idx     <= n_idx;
        r_n       <= n_n;
        r_ochar   <= n_ochar;
        r_olast   <= n_olast;
        r_onochar <= n_onochar;
    end

    assign i_in.ready     = w_ready;
    assign o_out.valid    = r_ovalid;
    assign o_out.out_char = r_ochar;
    assign o_out.out_last = r_olast;
    assign o_out.no_char  = r_onochar;

    `SCT_ASSERT(a_res_bound, r_state != S_LOAD |-> r_n < RES_W'(MAX_RESULTS), "result count overrun")
    `SCT_ASSERT(a_read_in_range, r_state == S_DATA |-> $past(r_idx) < IDX_W'(r_len), "read past length")
    `SCT_ASSERT(a_count_bound, r_count <= CNT_W'(MAX_CHARS), "stored count past depth")
    `SCT_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> r_state == S_LOAD && !r_ovalid, "reset not idle")

endmodule

/* dv/tb.sv */
// testbench for square_columnar_transposer: drives message bytes, predicts each
// column walk in a scoreboard queue and checks every output request against it
// depends on sct_pkg, sct_in_if, sct_out_if and the design top level
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sct_pkg::*;

    localparam int CLK_HALF_NS  = 5;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 2 * MAX_RESULTS + 16;
    localparam int TIMEOUT_NS   = 2_000_000;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eom;
        logic              nochar;
    } t_cipher;

    typedef logic [CHAR_W-1:0] t_plain_q[$];

    logic i_clk;
    logic i_rst_n;

    sct_in_if  in_if();
    sct_out_if out_if();

    square_columnar_transposer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic [CHAR_W-1:0] plain_store [MAX_CHARS_DEF];
    int                plain_count;
    t_cipher           cipher_q[$];
    int                mismatches;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                counted_items;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.in_char = NUL_CHAR;
        in_if.in_last = 1'b0;
        out_if.ready = 1'b0;
    end

    always begin
        #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // stores a byte, queues the column walk, one entry per output request
    task automatic absorb_plain_byte(input logic [CHAR_W-1:0] ch, input logic last);
        t_cipher burst[$];
        int      len;
        int      cols;
        int      n;
        if (ch != NUL_CHAR && ch != SPACE_CHAR && plain_count < MAX_CHARS_DEF) begin
            plain_store[plain_count] = ch;
            plain_count++;
        end
        if (last) begin
            len = plain_count;
            plain_count = 0;
            if (len == 0) begin
                cipher_q.push_back('{ch: NUL_CHAR, eom: 1'b1, nochar: 1'b1});
            end else begin
                cols = 0;
                while (cols * cols < len) cols++;
                n = 0;
                for (int x = 0; x < cols && n < MAX_RESULTS; x++) begin
                    for (int idx = x; idx < len && n < MAX_RESULTS; idx += cols) begin
                        burst.push_back('{ch: plain_store[idx], eom: 1'b0, nochar: 1'b0});
                        n++;
                    end
                    if (n < MAX_RESULTS) begin
                        burst.push_back('{ch: SPACE_CHAR, eom: 1'b0, nochar: 1'b0});
                        n++;
                    end
                end
                burst[burst.size() - 1].eom = 1'b1;
                foreach (burst[i]) cipher_q.push_back(burst[i]);
            end
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.in_char <= ch;
        in_if.in_last <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        absorb_plain_byte(ch, last);
        if (last || (ch != NUL_CHAR && ch != SPACE_CHAR)) counted_items++;
        @(negedge i_clk);
    endtask

    task automatic send_message(input t_plain_q msg);
        foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
    endtask

    task automatic wait_cipher_drained();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (cipher_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [CHAR_W-1:0] pick_plain_byte();
        int r;
        r = $urandom_range(99);
        if (r < 6) return NUL_CHAR;
        if (r < 12) return SPACE_CHAR;
        return CHAR_W'($urandom_range(255));
    endfunction

    task automatic test_empty_messages();
        send_message({NUL_CHAR});
        send_message({SPACE_CHAR});
        send_message({SPACE_CHAR, NUL_CHAR, SPACE_CHAR});
    endtask

    task automatic test_extreme_bytes();
        send_message({8'hFF});
        send_message({8'h01, 8'hFF, 8'h7F, 8'h80, 8'h1F, 8'h21});
    endtask

    task automatic test_dropped_last();
        send_message({8'h41, 8'h42, 8'h43, SPACE_CHAR});
        send_message({8'h44, NUL_CHAR, 8'h45, NUL_CHAR});
    endtask

    task automatic test_square_lengths();
        send_message({8'h61, 8'h62, 8'h63, 8'h64});
        send_message({8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39});
    endtask

    // more kept bytes than the store holds, last one lands past the end
    task automatic test_store_overflow();
        for (int i = 0; i < MAX_CHARS_DEF + 3; i++) begin
            send_byte(CHAR_W'(8'h41 + (i % 26)), 1'b0);
        end
        send_byte(8'h5A, 1'b1);
        for (int i = 0; i < MAX_CHARS_DEF + 1; i++) begin
            send_byte(CHAR_W'(8'h61 + (i % 26)), 1'b0);
        end
        send_byte(NUL_CHAR, 1'b1);
    endtask

    // sender holds off until the whole column walk is out
    task automatic test_drain_pause();
        send_message({8'h48, 8'h45, 8'h4C, 8'h4C, 8'h4F});
        wait_cipher_drained();
        send_message({8'h57, 8'h4F, 8'h52, 8'h4C, 8'h44});
    endtask

    task automatic test_random_traffic(input int s_pct, input int r_pct, input int items);
        int target;
        int len;
        int r;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        target = counted_items + items;
        while (counted_items < target) begin
            r = $urandom_range(11);
            if (r == 0) len = $urandom_range(40, 60);
            else if (r == 1) len = 1;
            else len = $urandom_range(2, 20);
            for (int i = 0; i < len; i++) begin
                send_byte(pick_plain_byte(), i == len - 1);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_cipher want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (cipher_q.size() == 0) begin
                $error("unexpected request: out_char %h out_last %b no_char %b",
                       out_if.out_char, out_if.out_last, out_if.no_char);
                mismatches++;
            end else begin
                want = cipher_q.pop_front();
                if (out_if.out_char !== want.ch) begin
                    $error("out_char: expected %h, got %h", want.ch, out_if.out_char);
                    mismatches++;
                end
                if (out_if.out_last !== want.eom) begin
                    $error("out_last: expected %b, got %b", want.eom, out_if.out_last);
                    mismatches++;
                end
                if (out_if.no_char !== want.nochar) begin
                    $error("no_char: expected %b, got %b", want.nochar, out_if.no_char);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        plain_count = 0;
        mismatches = 0;
        counted_items = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_messages();
        test_extreme_bytes();
        test_dropped_last();
        test_square_lengths();
        test_drain_pause();
        send_idle_pct = 28;
        recv_idle_pct = 69;
        test_store_overflow();

        test_random_traffic(28, 69, 80);
        test_random_traffic(69, 28, 80);
        test_random_traffic(0, 0, 80);

        wait_cipher_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && cipher_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
